>>> rtl/core/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Types and constants shared by the sorted table search core.
// ----------------------------------------------------------------------------
`default_nettype none
package stbs_pkg;
   localparam int CAPACITY      = 64;
   localparam int PAYLOAD_WIDTH = 64;
   localparam int ADDR_W        = $clog2(CAPACITY);
   localparam int CNT_W         = ADDR_W + 1;
   localparam int ENTRY_W       = 3 * 64 + PAYLOAD_WIDTH;

   typedef enum logic [2:0] {
      KIND_LOOKUP = 3'd0,
      KIND_PUT    = 3'd1,
      KIND_DEL    = 3'd2,
      KIND_INS    = 3'd3,
      KIND_DELPOS = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_LIMIT = 2'd0,
      CSR_WORDS = 2'd1,
      CSR_WIDE  = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_CMP, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR, S_WRITE, S_OUT
   } state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] key_a;
      logic [63:0] key_b;
      logic [63:0] key_c;
      logic [63:0] payload;
      logic [6:0]  position;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  slot;
      logic [63:0] payload_out;
      logic [6:0]  entries_now;
   } rsp_type;

   typedef struct packed {
      logic [6:0] limit;
      logic [1:0] words;
      logic       wide;
   } cfg_type;

   function automatic logic [63:0] order_of(input logic [63:0] w, input logic wide);
      logic [63:0] v;
      v = wide ? w : {{32{w[31]}}, w[31:0]};
      return v ^ 64'h8000_0000_0000_0000;
   endfunction
endpackage
`default_nettype wire

>>> rtl/core/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module stbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/core/stbs_cmp.sv
// ----------------------------------------------------------------------------
// stbs_cmp
// Lexicographic key compare of a stored entry against the request key.
// ----------------------------------------------------------------------------
`default_nettype none
module stbs_cmp
   import stbs_pkg::*;
(
   input  wire logic [63:0] ea,
   input  wire logic [63:0] eb,
   input  wire logic [63:0] ec,
   input  wire logic [63:0] ka,
   input  wire logic [63:0] kb,
   input  wire logic [63:0] kc,
   input  wire cfg_type     cfg,
   output logic             gt,
   output logic             eq
);
   logic [63:0] oa, ob, oc, pa, pb, pc;
   logic        use_b, use_c;
   always_comb begin
      oa = order_of(ea, cfg.wide);
      ob = order_of(eb, cfg.wide);
      oc = order_of(ec, cfg.wide);
      pa = order_of(ka, cfg.wide);
      pb = order_of(kb, cfg.wide);
      pc = order_of(kc, cfg.wide);
      use_b = cfg.words >= 2'd2;
      use_c = cfg.words == 2'd3;
      if (oa != pa) begin
         gt = oa > pa;
         eq = 1'b0;
      end else if (use_b && ob != pb) begin
         gt = ob > pb;
         eq = 1'b0;
      end else if (use_c && oc != pc) begin
         gt = oc > pc;
         eq = 1'b0;
      end else begin
         gt = 1'b0;
         eq = 1'b1;
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Sorted key table with binary search, ordered insert and delete.
//
// Requests enter on req_valid/req_ready; one response leaves per request on
// rsp_valid/rsp_ready. One request is in flight at a time. A search makes
// up to log2(CAPACITY)+1 probes, each a memory read and then a compare,
// plus a final read when it ends without a match. An insert then moves
// each entry from the slot upward one place up, a delete each entry above
// the slot one place down, a read and then a write per entry through the
// single read port of the entry memory. The response register holds its
// value while rsp_ready is low; the following request is still accepted
// and runs, but its response waits in the output state until the earlier
// one is taken. Synchronous reset empties the table (count to zero) and
// restores table_limit 64, key_words 1 and key_word_wide 1; memory contents
// are not cleared. CSR writes apply immediately and are meant for idle time.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_table_binary_search_core
   import stbs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_data
);
   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CNT_W-1:0] total_ff, total_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0] idx_ff, idx_in, at_ff, at_in;
   logic [1:0]  status_ff, status_in;
   logic [63:0] pout_ff, pout_in;
   logic        found_ff, found_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic               cmp_gt, cmp_eq;
   logic [CNT_W-1:0]   mid, limit;
   logic               accept, ins_op;

   stbs_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   stbs_cmp u_cmp (
      .ea(rd_data[ENTRY_W-1 -: 64]), .eb(rd_data[ENTRY_W-65 -: 64]),
      .ec(rd_data[ENTRY_W-129 -: 64]),
      .ka(req_ff.key_a), .kb(req_ff.key_b), .kc(req_ff.key_c),
      .cfg(cfg_ff), .gt(cmp_gt), .eq(cmp_eq)
   );

   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign limit  = (cfg_ff.limit > 7'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(cfg_ff.limit);
   assign accept = req_valid && req_ready;
   assign ins_op = req_ff.kind == KIND_PUT || req_ff.kind == KIND_INS;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LIMIT: cfg_in.limit = csr_data;
            CSR_WORDS: cfg_in.words = csr_data[1:0];
            CSR_WIDE:  cfg_in.wide  = csr_data[0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (accept) begin
            state_in = (req_data.kind inside {KIND_LOOKUP, KIND_PUT, KIND_DEL}) ? S_RD
                                                                               : S_DECIDE;
         end
         S_RD:     state_in = (lo_ff < hi_ff) ? S_CMP : S_DECIDE;
         S_CMP:    state_in = cmp_eq ? S_DECIDE : S_RD;
         S_DECIDE: state_in = S_SHIFT_RD;
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_WRITE:  state_in = S_OUT;
         S_OUT:    if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
      if (state_ff == S_RD && lo_ff < hi_ff) begin
         state_in = S_CMP;
      end
      if (state_ff == S_DECIDE) begin
         state_in = S_OUT;
         if (status_in == ST_OK && !(req_ff.kind == KIND_LOOKUP)
             && !(req_ff.kind == KIND_PUT && found_ff)) begin
            state_in = S_SHIFT_RD;
         end
         if (status_in == ST_OK && req_ff.kind == KIND_PUT && found_ff) state_in = S_WRITE;
      end
      if (state_ff == S_SHIFT_RD) begin
         if (ins_op ? (idx_ff == at_ff) : (idx_ff + 1'b1 >= total_ff)) begin
            state_in = ins_op ? S_WRITE : S_OUT;
         end
      end
   end

   // datapath
   always_comb begin
      lo_in = lo_ff; hi_in = hi_ff; idx_in = idx_ff; at_in = at_ff;
      status_in = status_ff; pout_in = pout_ff; found_in = found_ff;
      total_in = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      rd_addr = mid[ADDR_W-1:0];
      wr_en = 1'b0;
      wr_addr = idx_ff[ADDR_W-1:0];
      wr_data = rd_data;
      case (state_ff)
         S_IDLE: if (accept) begin
            lo_in = '0; hi_in = total_ff; found_in = 1'b0;
            status_in = ST_OK; pout_in = '0;
         end
         S_CMP: if (cmp_eq) begin
            found_in = 1'b1; lo_in = mid;
         end else if (cmp_gt) begin
            hi_in = mid;
         end else begin
            lo_in = mid + 1'b1;
         end
         S_DECIDE: begin
            at_in = lo_ff;
            case (req_ff.kind)
               KIND_LOOKUP: begin
                  status_in = found_ff ? ST_OK : ST_MISS;
                  if (found_ff) pout_in = rd_data[PAYLOAD_WIDTH-1:0];
               end
               KIND_PUT: if (!found_ff && (total_ff + 1'b1 > limit || lo_ff >= limit))
                  status_in = ST_FULL;
               KIND_DEL: status_in = found_ff ? ST_OK : ST_MISS;
               KIND_INS: begin
                  at_in = req_ff.position;
                  if (total_ff + 1'b1 > limit || req_ff.position >= limit) status_in = ST_FULL;
                  else if (req_ff.position > total_ff) status_in = ST_BADPOS;
               end
               KIND_DELPOS: begin
                  at_in = req_ff.position;
                  if (req_ff.position >= total_ff) status_in = ST_BADPOS;
               end
               default: begin
                  at_in = req_ff.position;
                  status_in = ST_BADPOS;
               end
            endcase
            idx_in = ins_op ? total_ff : at_in;
         end
         S_SHIFT_RD: begin
            if (ins_op) begin
               rd_addr = idx_ff[ADDR_W-1:0] - 1'b1;
               if (idx_ff == at_ff) total_in = total_ff + 1'b1;
            end else begin
               rd_addr = idx_ff[ADDR_W-1:0] + 1'b1;
               if (idx_ff + 1'b1 >= total_ff) total_in = total_ff - 1'b1;
            end
         end
         S_SHIFT_WR: begin
            wr_en = 1'b1;
            idx_in = ins_op ? idx_ff - 1'b1 : idx_ff + 1'b1;
         end
         S_WRITE: begin
            wr_en = 1'b1;
            wr_addr = at_ff[ADDR_W-1:0];
            wr_data = {req_ff.key_a, req_ff.key_b, req_ff.key_c,
                       req_ff.payload[PAYLOAD_WIDTH-1:0]};
         end
         S_OUT: if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_in = 1'b1;
            rsp_in.status = status_ff;
            rsp_in.slot = at_ff;
            rsp_in.payload_out = pout_ff;
            rsp_in.entries_now = total_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cfg_ff <= '{limit: 7'd64, words: 2'd1, wide: 1'b1};
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cfg_ff <= cfg_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) req_ff <= req_data;
      lo_ff <= lo_in; hi_ff <= hi_in; idx_ff <= idx_in; at_ff <= at_in;
      status_ff <= status_in; pout_ff <= pout_in; found_ff <= found_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(CAPACITY)) else $error("entry count overflow");
   a_one: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready) else $error("second request accepted in flight");
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped");
`endif
endmodule
`default_nettype wire
